/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbc_pkg.sv */
package sbc_pkg;

  // Default sizes
  localparam int DEF_MAX_FB_WIDTH   = 256;
  localparam int DEF_MAX_FB_HEIGHT  = 256;
  localparam int DEF_SPRITE_SLOTS   = 16;
  localparam int DEF_MAX_SPRITE_DIM = 16;

  // Fixed field widths
  localparam int CFG_W    = 9;
  localparam int COLOR_W  = 32;
  localparam int MASK_W   = 16;
  localparam int WRCNT_W  = 17;
  localparam int IN_DW    = 88;
  localparam int OUT_DW   = 56;
  localparam int OUT_PAD  = OUT_DW - COLOR_W - WRCNT_W;

  // Register reset values
  localparam logic [CFG_W-1:0] FB_WIDTH_RST  = 9'd224;
  localparam logic [CFG_W-1:0] FB_HEIGHT_RST = 9'd256;

  // Register indexes
  localparam logic CFG_FB_WIDTH  = 1'b0;
  localparam logic CFG_FB_HEIGHT = 1'b1;

  // Command codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_DRAW  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

endpackage

/* rtl/sprite_blitter_with_clip_core.sv */
// Load, rejected draw and out-of-range read go straight to the result; an in-range read
//   passes RD_BASE, RD_ISSUE, RD_WAIT; clear writes width*height pixels (clipped sizes);
//   draw scans sprite_height rows of min(sprite_width, 16) columns, both sat. at 16.
// One command at a time, one pixel per cycle through the single frame store port;
//   the next is taken once the result is registered, which waits for an unread word.
// Reset (rst, synchronous): sequencer idle, no result, fb 224 x 256; stores keep contents.
`include "assert_macros.svh"

module sprite_blitter_with_clip_core #(
  parameter int MAX_FB_WIDTH   = sbc_pkg::DEF_MAX_FB_WIDTH,
  parameter int MAX_FB_HEIGHT  = sbc_pkg::DEF_MAX_FB_HEIGHT,
  parameter int SPRITE_SLOTS   = sbc_pkg::DEF_SPRITE_SLOTS,
  parameter int MAX_SPRITE_DIM = sbc_pkg::DEF_MAX_SPRITE_DIM
) (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // slot[3:0], sprite_row[7:4], row_bits[23:8], sprite_width[28:24],
  // sprite_height[33:29], x_pos[42:34], y_pos[51:43], color[83:52], zero pad
  input  logic [sbc_pkg::IN_DW-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [1:0]                 s_tuser,
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // read_color[31:0], pixels_written[48:32], zero pad
  output logic [sbc_pkg::OUT_DW-1:0] m_tdata,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [sbc_pkg::CFG_W-1:0]  cfg_data
);

  localparam int FB_DEPTH = MAX_FB_WIDTH * MAX_FB_HEIGHT;
  localparam int AW       = $clog2(FB_DEPTH);
  localparam int MS_DEPTH = SPRITE_SLOTS * MAX_SPRITE_DIM;
  localparam int MAW      = $clog2(MS_DEPTH);
  localparam int DIM_W    = $clog2(MAX_SPRITE_DIM + 1);
  localparam int ROW_W    = $clog2(MAX_SPRITE_DIM);
  localparam int CNT_W    = 18;   // up to 511 * 511 pixels
  localparam int DCNT_W   = $clog2(MAX_SPRITE_DIM * sbc_pkg::MASK_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR_SIZE, ST_CLR_RUN, ST_ROW_FETCH, ST_ROW_BASE, ST_COL,
    ST_RD_BASE, ST_RD_ISSUE, ST_RD_WAIT, ST_FINISH
  } state_t;

  state_t state;

  logic [sbc_pkg::CFG_W-1:0]   fb_width, fb_height;
  logic [8:0]                  ew, eh;

  // input word fields
  logic [1:0]                  in_req;
  logic [3:0]                  in_slot, in_row;
  logic [sbc_pkg::MASK_W-1:0]  in_bits;
  logic [4:0]                  in_sw, in_sh;
  logic [8:0]                  in_x, in_y;
  logic [sbc_pkg::COLOR_W-1:0] in_color;
  logic                        in_slot_ok, in_row_ok;
  logic [DIM_W-1:0]            in_sw_sat, in_sh_sat;
  logic [4:0]                  in_ncols;
  logic                        accept;

  // command registers
  logic [8:0]                  x_q, y_q;
  logic [sbc_pkg::COLOR_W-1:0] color_q;
  logic [DIM_W-1:0]            sh_q;
  logic [4:0]                  ncols_q;
  logic [MAW-1:0]              mask_base;
  logic [ROW_W-1:0]            row_q;
  logic [3:0]                  col_q;
  logic [10:0]                 py_q;
  logic                        row_hit;
  logic [17:0]                 row_base;
  logic [DCNT_W-1:0]           dcnt, dcnt_next;
  logic [CNT_W-1:0]            clr_n, clr_idx;
  logic [sbc_pkg::COLOR_W-1:0] res_color;
  logic [sbc_pkg::WRCNT_W-1:0] res_written;
  logic [sbc_pkg::COLOR_W-1:0] out_color;
  logic [sbc_pkg::WRCNT_W-1:0] out_written;

  // datapath
  logic [9:0]                  px;
  logic                        pix_hit;
  logic [18:0]                 addr_sum;
  logic                        row_last, col_last;

  // stores
  logic [sbc_pkg::COLOR_W-1:0] frame_mem [FB_DEPTH];
  logic [sbc_pkg::MASK_W-1:0]  mask_mem [MS_DEPTH];
  logic                        fs_we, fs_rd_en;
  logic [AW-1:0]               fs_addr;
  logic [sbc_pkg::COLOR_W-1:0] fs_rd_data;
  logic                        ms_we, ms_rd_en;
  logic [MAW-1:0]              ms_addr;
  logic [sbc_pkg::MASK_W-1:0]  ms_rd_data;

  always_comb begin
    ew = (int'(fb_width) > MAX_FB_WIDTH) ? 9'(MAX_FB_WIDTH) : fb_width;
    eh = (int'(fb_height) > MAX_FB_HEIGHT) ? 9'(MAX_FB_HEIGHT) : fb_height;

    in_req   = s_tuser;
    in_slot  = s_tdata[3:0];
    in_row   = s_tdata[7:4];
    in_bits  = s_tdata[23:8];
    in_sw    = s_tdata[28:24];
    in_sh    = s_tdata[33:29];
    in_x     = s_tdata[42:34];
    in_y     = s_tdata[51:43];
    in_color = s_tdata[83:52];

    in_slot_ok = int'(in_slot) < SPRITE_SLOTS;
    in_row_ok  = int'(in_row) < MAX_SPRITE_DIM;
    in_sw_sat  = (int'(in_sw) > MAX_SPRITE_DIM) ? DIM_W'(MAX_SPRITE_DIM) : DIM_W'(in_sw);
    in_sh_sat  = (int'(in_sh) > MAX_SPRITE_DIM) ? DIM_W'(MAX_SPRITE_DIM) : DIM_W'(in_sh);
    // columns past the mask width are never drawn
    in_ncols   = (int'(in_sw_sat) > sbc_pkg::MASK_W) ? 5'(sbc_pkg::MASK_W)
                                                       : 5'(in_sw_sat);

    s_tready = (state == ST_IDLE);
    accept   = s_tvalid && s_tready;

    px        = 10'(x_q) + 10'(col_q);
    pix_hit   = row_hit && ms_rd_data[col_q] && (px < 10'(ew));
    dcnt_next = dcnt + DCNT_W'(pix_hit);
    row_last  = (DIM_W'(row_q) + DIM_W'(1)) == sh_q;
    col_last  = (5'(col_q) + 5'd1) == ncols_q;

    addr_sum = 19'(row_base) + ((state == ST_COL) ? 19'(px) : 19'(x_q));

    fs_we    = ((state == ST_CLR_RUN) && (clr_idx < clr_n)) ||
               ((state == ST_COL) && pix_hit);
    fs_rd_en = (state == ST_RD_ISSUE);
    fs_addr  = (state == ST_CLR_RUN) ? AW'(clr_idx) : AW'(addr_sum);

    ms_we    = accept && (in_req == sbc_pkg::REQ_LOAD) && in_slot_ok && in_row_ok;
    ms_rd_en = (state == ST_ROW_FETCH);
    ms_addr  = ms_rd_en ? (mask_base + MAW'(row_q))
                        : MAW'(int'(in_slot) * MAX_SPRITE_DIM + int'(in_row));

    m_tdata = {sbc_pkg::OUT_PAD'(0), out_written, out_color};
  end

  always_ff @(posedge clk) begin
    if (fs_we) frame_mem[fs_addr] <= color_q;
    if (fs_rd_en) fs_rd_data <= frame_mem[fs_addr];
  end

  always_ff @(posedge clk) begin
    if (ms_we) mask_mem[ms_addr] <= in_bits;
    if (ms_rd_en) ms_rd_data <= mask_mem[ms_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      fb_width  <= sbc_pkg::FB_WIDTH_RST;
      fb_height <= sbc_pkg::FB_HEIGHT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          sbc_pkg::CFG_FB_WIDTH:  fb_width  <= cfg_data;
          sbc_pkg::CFG_FB_HEIGHT: fb_height <= cfg_data;
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_FINISH)) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            x_q         <= in_x;
            y_q         <= in_y;
            color_q     <= in_color;
            sh_q        <= in_sh_sat;
            ncols_q     <= in_ncols;
            mask_base   <= MAW'(int'(in_slot) * MAX_SPRITE_DIM);
            row_q       <= '0;
            dcnt        <= '0;
            res_color   <= '0;
            res_written <= '0;
            unique case (in_req)
              sbc_pkg::REQ_CLEAR: state <= ST_CLR_SIZE;
              sbc_pkg::REQ_LOAD:  state <= ST_FINISH;
              sbc_pkg::REQ_DRAW: begin
                if (in_slot_ok && (in_sh_sat != '0) && (in_ncols != '0))
                  state <= ST_ROW_FETCH;
                else
                  state <= ST_FINISH;
              end
              sbc_pkg::REQ_READ: begin
                if ((in_x < ew) && (in_y < eh)) state <= ST_RD_BASE;
                else state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_CLR_SIZE: begin
          clr_n   <= CNT_W'(ew) * CNT_W'(eh);
          clr_idx <= '0;
          state   <= ST_CLR_RUN;
        end
        ST_CLR_RUN: begin
          if (clr_idx == clr_n) begin
            res_written <= sbc_pkg::WRCNT_W'(clr_n);
            state       <= ST_FINISH;
          end else begin
            clr_idx <= clr_idx + CNT_W'(1);
          end
        end
        ST_ROW_FETCH: begin
          // sprite row r lands on y + h - 1 - r
          py_q  <= 11'(y_q) + 11'(sh_q) - 11'd1 - 11'(row_q);
          state <= ST_ROW_BASE;
        end
        ST_ROW_BASE: begin
          row_base <= py_q[8:0] * ew;
          row_hit  <= py_q < 11'(eh);
          col_q    <= '0;
          state    <= ST_COL;
        end
        ST_COL: begin
          dcnt  <= dcnt_next;
          col_q <= col_q + 4'd1;
          if (col_last) begin
            if (row_last) begin
              res_written <= sbc_pkg::WRCNT_W'(dcnt_next);
              state       <= ST_FINISH;
            end else begin
              row_q <= row_q + ROW_W'(1);
              state <= ST_ROW_FETCH;
            end
          end
        end
        ST_RD_BASE: begin
          row_base <= y_q * ew;
          state    <= ST_RD_ISSUE;
        end
        ST_RD_ISSUE: state <= ST_RD_WAIT;
        ST_RD_WAIT: begin
          res_color <= fs_rd_data;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_color   <= res_color;
            out_written <= res_written;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SBC_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "ready high right after accept")
  `SBC_ASSERT_IMP(a_write_states, fs_we, state == ST_CLR_RUN || state == ST_COL, "stray write")
  `SBC_ASSERT_IMP(a_clear_bound, state == ST_CLR_RUN, clr_idx <= clr_n, "clear past end")
  `SBC_ASSERT_IMP(a_read_count, m_tvalid && out_color != '0, out_written == '0, "count on read")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT = 200000;
  localparam int DIM = sbc_pkg::DEF_MAX_SPRITE_DIM;
  localparam int FRAME_N = sbc_pkg::DEF_MAX_FB_WIDTH * sbc_pkg::DEF_MAX_FB_HEIGHT;
  localparam int MASK_N = sbc_pkg::DEF_SPRITE_SLOTS * DIM;

  typedef struct {
    bit [1:0]  op;
    bit [3:0]  slot;
    bit [3:0]  srow;
    bit [15:0] bits;
    bit [4:0]  sw;
    bit [4:0]  sh;
    bit [8:0]  x;
    bit [8:0]  y;
    bit [31:0] color;
  } cmd_t;

  typedef struct {
    bit [sbc_pkg::COLOR_W-1:0] color;
    bit [sbc_pkg::WRCNT_W-1:0] count;
  } blit_res_t;

  class blit_scoreboard;
    bit [31:0] frame [FRAME_N];
    bit        frame_set [FRAME_N];
    bit [15:0] masks [MASK_N];
    bit        mask_set [MASK_N];
    bit [8:0]  fb_w = sbc_pkg::FB_WIDTH_RST;
    bit [8:0]  fb_h = sbc_pkg::FB_HEIGHT_RST;
    blit_res_t pending [$];
    int        errors;
    int        checked;

    function int eff_w();
      return (fb_w > sbc_pkg::DEF_MAX_FB_WIDTH) ? sbc_pkg::DEF_MAX_FB_WIDTH : int'(fb_w);
    endfunction

    function int eff_h();
      return (fb_h > sbc_pkg::DEF_MAX_FB_HEIGHT) ? sbc_pkg::DEF_MAX_FB_HEIGHT : int'(fb_h);
    endfunction

    function void set_reg(logic addr, bit [8:0] v);
      if (addr == sbc_pkg::CFG_FB_WIDTH) fb_w = v;
      else fb_h = v;
    endfunction

    // consecutive rows of a slot that hold a loaded mask, from row 0
    function int rows_ready(int s);
      int k;
      k = 0;
      while (k < DIM && mask_set[s*DIM+k]) k++;
      return k;
    endfunction

    function void note_command(cmd_t c);
      int w, h, sw, sh, py, px, n;
      bit [15:0] m;
      blit_res_t res;
      w = eff_w();
      h = eff_h();
      n = 0;
      res.color = '0;
      case (c.op)
        sbc_pkg::REQ_CLEAR: begin
          n = w * h;
          for (int i = 0; i < n; i++) begin
            frame[i] = c.color;
            frame_set[i] = 1'b1;
          end
        end
        sbc_pkg::REQ_LOAD: begin
          masks[int'(c.slot)*DIM + int'(c.srow)] = c.bits;
          mask_set[int'(c.slot)*DIM + int'(c.srow)] = 1'b1;
        end
        sbc_pkg::REQ_DRAW: begin
          sw = (c.sw > DIM) ? DIM : int'(c.sw);
          sh = (c.sh > DIM) ? DIM : int'(c.sh);
          for (int r = 0; r < sh; r++) begin
            m = masks[int'(c.slot)*DIM + r];
            py = int'(c.y) + sh - 1 - r;   // vertical flip
            if (py < h) begin
              for (int col = 0; col < sw; col++) begin
                px = int'(c.x) + col;
                if (m[col] && px < w) begin
                  frame[py*w + px] = c.color;
                  frame_set[py*w + px] = 1'b1;
                  n++;
                end
              end
            end
          end
        end
        default: begin
          if (c.x < w && c.y < h) res.color = frame[int'(c.y)*w + int'(c.x)];
        end
      endcase
      res.count = n[sbc_pkg::WRCNT_W-1:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic [sbc_pkg::OUT_DW-1:0] d);
      blit_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: read_color %h pixels_written %0d",
               d[31:0], d[48:32]);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[31:0] !== e.color) begin
        $error("read_color: expected %h, got %h", e.color, d[31:0]);
        errors++;
      end
      if (d[48:32] !== e.count) begin
        $error("pixels_written: expected %0d, got %0d", e.count, d[48:32]);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [sbc_pkg::IN_DW-1:0]  s_tdata;
  logic [1:0]                 s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [sbc_pkg::OUT_DW-1:0] m_tdata;
  logic                       cfg_we;
  logic                       cfg_addr;
  logic [sbc_pkg::CFG_W-1:0]  cfg_data;

  blit_scoreboard sb = new();
  bit quiet;
  int n_sent;
  int n_ops [4];
  int n_settings;
  int idle_cycles;

  sprite_blitter_with_clip_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink with random stalls
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op    = 2'($urandom_range(0, 3));
    c.slot  = 4'($urandom_range(0, 15));
    c.srow  = 4'($urandom_range(0, 15));
    c.bits  = 16'($urandom_range(0, 65535));
    c.sw    = 5'($urandom_range(0, 31));
    c.sh    = 5'($urandom_range(0, 31));
    c.x     = 9'($urandom_range(0, 511));
    c.y     = 9'($urandom_range(0, 511));
    c.color = $urandom;
    return c;
  endfunction

  function automatic cmd_t make_cmd(bit [1:0] op, bit [3:0] slot, bit [3:0] srow,
                                    bit [15:0] bits, bit [4:0] sw, bit [4:0] sh,
                                    bit [8:0] x, bit [8:0] y, bit [31:0] color);
    cmd_t c;
    c.op = op; c.slot = slot; c.srow = srow; c.bits = bits;
    c.sw = sw; c.sh = sh; c.x = x; c.y = y; c.color = color;
    return c;
  endfunction

  // keep away from store entries that were never written
  function automatic cmd_t legalise(cmd_t c);
    int w, h, k, sh;
    w = sb.eff_w();
    h = sb.eff_h();
    if (c.op == sbc_pkg::REQ_READ) begin
      if (c.x < w && c.y < h && !sb.frame_set[int'(c.y)*w + int'(c.x)]) c.x = 9'd511;
    end else if (c.op == sbc_pkg::REQ_DRAW) begin
      k = sb.rows_ready(int'(c.slot));
      sh = (c.sh > DIM) ? DIM : int'(c.sh);
      if (sh > k) c.sh = (k == 0) ? 5'd0 : 5'($urandom_range(1, k));
    end
    return c;
  endfunction

  function automatic bit [8:0] place(int lim);
    int v;
    case ($urandom_range(0, 2))
      0:       v = lim - int'($urandom_range(0, 20));
      1:       v = $urandom_range(0, lim);
      default: v = $urandom_range(0, 511);
    endcase
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return v[8:0];
  endfunction

  // entered and left at a falling edge
  task automatic send_cmd(cmd_t c);
    int gap;
    c = legalise(c);
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {4'b0, c.color, c.y, c.x, c.sh, c.sw, c.bits, c.srow, c.slot};
    s_tuser  <= c.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_command(c);
    n_sent++;
    n_ops[c.op]++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic write_reg(logic addr, bit [8:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(addr, v);
    @(negedge clk);
  endtask

  // load some rows of one slot, draw it near the edges, read back around it
  task automatic sprite_scene();
    int s, rows, w, h;
    cmd_t c, q;
    s = $urandom_range(0, 15);
    rows = $urandom_range(1, DIM);
    w = sb.eff_w();
    h = sb.eff_h();
    for (int r = 0; r < rows; r++) begin
      c = random_cmd();
      c.op = sbc_pkg::REQ_LOAD;
      c.slot = 4'(s);
      c.srow = 4'(r);
      case ($urandom_range(0, 5))
        0:       c.bits = '0;
        1:       c.bits = '1;
        default: ;
      endcase
      send_cmd(c);
    end
    repeat ($urandom_range(1, 3)) begin
      c = random_cmd();
      c.op = sbc_pkg::REQ_DRAW;
      c.slot = 4'(s);
      c.sw = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(1, DIM));
      c.sh = (rows == DIM && $urandom_range(0, 3) == 0) ? 5'($urandom_range(16, 31))
                                                       : 5'($urandom_range(1, rows));
      c.x = place(w);
      c.y = place(h);
      send_cmd(c);
      repeat ($urandom_range(1, 3)) begin
        q = random_cmd();
        q.op = sbc_pkg::REQ_READ;
        q.x = c.x + 9'($urandom_range(0, 15));
        q.y = c.y + 9'($urandom_range(0, 15));
        send_cmd(q);
      end
    end
  endtask

  task automatic run_phase(bit [8:0] w, bit [8:0] h, int items);
    int stop;
    cmd_t c;
    drain();
    write_reg(sbc_pkg::CFG_FB_WIDTH, w);
    write_reg(sbc_pkg::CFG_FB_HEIGHT, h);
    n_settings++;
    quiet = ($urandom_range(0, 3) == 0);
    stop = n_sent + items;
    c = random_cmd();
    c.op = sbc_pkg::REQ_CLEAR;
    send_cmd(c);
    while (n_sent < stop) begin
      if ($urandom_range(0, 39) == 0) drain();
      if ($urandom_range(0, 3) == 0) begin
        c = random_cmd();
        // big clears are slow, keep them to the phase start
        if (c.op == sbc_pkg::REQ_CLEAR && sb.eff_w() * sb.eff_h() > 4096)
          c.op = sbc_pkg::REQ_READ;
        send_cmd(c);
      end else begin
        sprite_scene();
      end
    end
  endtask

  initial begin
    bit [8:0] widths [8];
    bit [8:0] heights [8];
    widths  = '{9'd511, 9'd1, 9'd0, 9'd37, 9'd256, 9'd9, 9'd100, 9'd224};
    heights = '{9'd300, 9'd1, 9'd9, 9'd0, 9'd8, 9'd256, 9'd60, 9'd256};
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, registers at their reset values (224 x 256)
    n_settings = 1;
    send_cmd(make_cmd(sbc_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 223, 255, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 224, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 256, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 15, 15, 16'hFFFF, 31, 31, 511, 511, 32'hFFFF_FFFF));
    send_cmd(make_cmd(sbc_pkg::REQ_LOAD, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_LOAD, 0, 1, 16'h0001, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_LOAD, 0, 2, 16'h8000, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_LOAD, 0, 3, 16'hA5A5, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_DRAW, 0, 0, 0, 16, 4, 0, 0, 32'h1234_5678));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 3, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 15, 0, 0));
    // clipped on the right and at the top, oversized width
    send_cmd(make_cmd(sbc_pkg::REQ_DRAW, 0, 0, 0, 31, 4, 216, 254, 32'h0));
    send_cmd(make_cmd(sbc_pkg::REQ_DRAW, 0, 0, 0, 0, 4, 10, 10, 32'hDEAD_BEEF));
    send_cmd(make_cmd(sbc_pkg::REQ_DRAW, 0, 0, 0, 5, 0, 10, 10, 32'hDEAD_BEEF));
    send_cmd(make_cmd(sbc_pkg::REQ_LOAD, 15, 15, 16'hFFFF, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 216, 254, 0));
    send_cmd(make_cmd(sbc_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 32'h0));

    foreach (widths[i]) run_phase(widths[i], heights[i], 84);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands: %0d clears, %0d loads, %0d draws, %0d reads",
             n_sent, n_ops[sbc_pkg::REQ_CLEAR], n_ops[sbc_pkg::REQ_LOAD],
             n_ops[sbc_pkg::REQ_DRAW], n_ops[sbc_pkg::REQ_READ]);
    $display("%0d results compared over %0d framebuffer sizes", sb.checked, n_settings);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
